// File: design/cbcd_pkg.sv
// shared types and constants for the complemented bcd frequency encoder
// used by cbcd_front, cbcd_cell and the top level; no dependencies
package cbcd_pkg;

	localparam int BIN_W     = 34;
	localparam int DIGITS    = 10;
	localparam int BCD_N     = (BIN_W * 30103) / 100000 + 1;
	localparam int BCD_W     = 4 * BCD_N;
	localparam int OUT_BYTES = 5;
	localparam int OUT_NIBS  = 2 * OUT_BYTES;
	localparam int CELLS     = BIN_W;
	localparam int SW_W      = 16;
	localparam int MODEL_W   = 2;
	localparam int IN_TDATA_W  = ((BIN_W + 7) / 8) * 8;
	localparam int OUT_TDATA_W = 8 * OUT_BYTES + SW_W;

	localparam logic [BIN_W-1:0] OFFSET_10MHZ = BIN_W'(100000000);
	localparam logic [7:0]       FIXUP_ADD    = 8'd10;

	localparam logic [MODEL_W-1:0] MODEL_PLAIN   = 2'd0;
	localparam logic [MODEL_W-1:0] MODEL_SUB10M  = 2'd1;
	localparam logic [MODEL_W-1:0] MODEL_TOP_FIX = 2'd2;

	localparam logic REG_MODEL  = 1'b0;
	localparam logic REG_SWITCH = 1'b1;

	localparam logic [MODEL_W-1:0] MODEL_RESET  = MODEL_PLAIN;
	localparam logic [SW_W-1:0]    SWITCH_RESET = 16'h0101;

	typedef struct packed {
		logic [BIN_W-1:0] bin;
		logic [BCD_W-1:0] bcd;
		logic             under;
		logic             fix;
	} item_t;

endpackage

// File: design/complemented_bcd_freq_encoder_unit.sv
// top level: config registers, entry stage, chain of double dabble cells, output packing
// depends on cbcd_pkg, cbcd_front, cbcd_cell
//
// channel   dir  tdata                                        tuser
// s_axis    in   freq_tenths_hz[33:0], zero fill to 40 bits   -
// m_axis    out  digit_byte0..4, switch_out (56 bits)         underflow
// cfg       in   cfg_we / cfg_index / cfg_data, index 0 model_select, 1 switch_word
//
// the pipeline is one entry stage plus one cell per input bit (34)
// one request accepted per cycle unless the output stalls; every cell is its own elastic stage
// a stalled output fills the chain before s_tready falls
// reset clears valids and loads model 0 and switch word 0x101
module complemented_bcd_freq_encoder_unit (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [cbcd_pkg::IN_TDATA_W-1:0]      s_tdata,  // freq_tenths_hz, zero fill
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [cbcd_pkg::OUT_TDATA_W-1:0]     m_tdata,  // digit_byte0..4, switch_out
	output logic [0:0]                           m_tuser,  // underflow
	input  logic                                 cfg_we,
	input  logic                                 cfg_index,
	input  logic [cbcd_pkg::SW_W-1:0]            cfg_data
);
	import cbcd_pkg::*;

	logic [MODEL_W-1:0] model_q;
	logic [SW_W-1:0]    switch_q;

	logic  vld   [CELLS+1];
	logic  rdy   [CELLS+1];
	item_t items [CELLS+1];

	logic [3:0]            nib   [OUT_NIBS];
	logic [8*OUT_BYTES-1:0] bytes_w;
	logic [7:0]            top_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			model_q  <= MODEL_RESET;
			switch_q <= SWITCH_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MODEL:  model_q  <= cfg_data[MODEL_W-1:0];
				REG_SWITCH: switch_q <= cfg_data;
				default: ;
			endcase
		end
	end

	cbcd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.model     (model_q),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_freq   (s_tdata[BIN_W-1:0]),
		.out_valid (vld[0]),
		.out_ready (rdy[0]),
		.out_item  (items[0])
	);

	for (genvar c = 0; c < CELLS; c++) begin : g_cell
		cbcd_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (vld[c]),
			.in_ready  (rdy[c]),
			.in_item   (items[c]),
			.out_valid (vld[c+1]),
			.out_ready (rdy[c+1]),
			.out_item  (items[c+1])
		);
	end

	assign rdy[CELLS] = m_tready;
	assign m_tvalid   = vld[CELLS];

	always_comb begin
		for (int i = 0; i < OUT_NIBS; i++) begin
			if (i < DIGITS && i < BCD_N) begin
				nib[i] = ~items[CELLS].bcd[4*i +: 4];
			end else begin
				nib[i] = 4'hF;
			end
		end
		for (int b = 0; b < OUT_BYTES; b++) begin
			bytes_w[8*b +: 8] = {nib[2*b+1], nib[2*b]};
		end
		top_byte = bytes_w[8*(OUT_BYTES-1) +: 8];
		// top-digit fixup model
		if (items[CELLS].fix && top_byte[4]) begin
			bytes_w[8*(OUT_BYTES-1) +: 8] = (top_byte + FIXUP_ADD) & 8'h0F;
		end
	end

	assign m_tdata = {switch_q, bytes_w};
	assign m_tuser = items[CELLS].under;

endmodule

// File: design/cbcd_front.sv
// entry stage: optional 10 MHz subtraction with saturation, seeds the bcd chain
// depends on cbcd_pkg
module cbcd_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [cbcd_pkg::MODEL_W-1:0] model,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [cbcd_pkg::BIN_W-1:0]   in_freq,
	output logic                         out_valid,
	input  logic                         out_ready,
	output cbcd_pkg::item_t              out_item
);
	import cbcd_pkg::*;

	logic  valid_q;
	item_t item_q;
	item_t item_d;

	assign in_ready  = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_item  = item_q;

	always_comb begin
		item_d.bcd   = '0;
		item_d.fix   = (model == MODEL_TOP_FIX);
		item_d.under = 1'b0;
		item_d.bin   = in_freq;
		if (model == MODEL_SUB10M) begin
			if (in_freq < OFFSET_10MHZ) begin
				item_d.bin   = '0;
				item_d.under = 1'b1;
			end else begin
				item_d.bin = in_freq - OFFSET_10MHZ;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_q <= item_d;
		end
	end

endmodule

// File: design/cbcd_cell.sv
// one double dabble step: add three to digits of five or more, shift in one bit
// depends on cbcd_pkg
module cbcd_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  cbcd_pkg::item_t in_item,
	output logic            out_valid,
	input  logic            out_ready,
	output cbcd_pkg::item_t out_item
);
	import cbcd_pkg::*;

	logic             valid_q;
	item_t            item_q;
	item_t            item_d;
	logic [BCD_W-1:0] adj;

	assign in_ready  = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_item  = item_q;

	always_comb begin
		for (int j = 0; j < BCD_N; j++) begin
			if (in_item.bcd[4*j +: 4] >= 4'd5) begin
				adj[4*j +: 4] = in_item.bcd[4*j +: 4] + 4'd3;
			end else begin
				adj[4*j +: 4] = in_item.bcd[4*j +: 4];
			end
		end
		item_d.bcd   = {adj[BCD_W-2:0], in_item.bin[BIN_W-1]};
		item_d.bin   = {in_item.bin[BIN_W-2:0], 1'b0};
		item_d.under = in_item.under;
		item_d.fix   = in_item.fix;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_q <= item_d;
		end
	end

endmodule

// File: test/tb.sv
// testbench for complemented_bcd_freq_encoder_unit: directed and random frequency requests,
// each result checked against a local predictor of the inverted bcd encoding
// depends on cbcd_pkg and the design top level
`timescale 1ns / 1ps

module tb;
	import cbcd_pkg::*;

	localparam logic [MODEL_W-1:0] MODEL_SPARE = 2'd3;
	localparam longint unsigned TEN_MHZ_TENTHS = 64'd100000000;
	localparam logic [7:0] TOP_FIX_ADD = 8'd10;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int RANDOM_PHASES = 8;
	localparam int PHASE_ITEMS = 200;

	typedef struct packed {
		logic [OUT_BYTES-1:0][7:0] digit_bytes;
		logic [SW_W-1:0]           switch_out;
		logic                      underflow;
	} freq_code_t;

	logic                   clk;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata = '0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic [0:0]             m_tuser;
	logic                   cfg_we = 1'b0;
	logic                   cfg_index = 1'b0;
	logic [SW_W-1:0]        cfg_data = '0;

	freq_code_t      code_q[$];
	logic [MODEL_W-1:0] model_cfg;
	logic [SW_W-1:0]    switch_cfg;
	bit  idle_on;
	int  errors;
	int  n_requests;
	int  n_settings;
	int  cycles;
	int  stall_left;

	complemented_bcd_freq_encoder_unit u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic freq_code_t encode_freq(input logic [BIN_W-1:0] freq,
			input logic [MODEL_W-1:0] model, input logic [SW_W-1:0] sw);
		longint unsigned v;
		logic [3:0] dig;
		freq_code_t r;
		int k;
		v = freq;
		r = '0;
		if (model == MODEL_SUB10M) begin
			if (v < TEN_MHZ_TENTHS) begin
				v = 0;
				r.underflow = 1'b1;
			end else begin
				v = v - TEN_MHZ_TENTHS;
			end
		end
		for (k = 0; k < OUT_NIBS; k++) begin
			dig = 4'(v % 10);
			r.digit_bytes[k / 2][(k % 2) * 4 +: 4] = ~dig;
			v = v / 10;
		end
		if (model == MODEL_TOP_FIX && r.digit_bytes[OUT_BYTES-1][4])
			r.digit_bytes[OUT_BYTES-1] = (r.digit_bytes[OUT_BYTES-1] + TOP_FIX_ADD) & 8'h0f;
		r.switch_out = sw;
		return r;
	endfunction

	function automatic int pick_idle();
		int r;
		r = $urandom_range(99);
		if (r < 70)
			return $urandom_range(3, 1);
		else if (r < 95)
			return $urandom_range(10, 4);
		return $urandom_range(60, 20);
	endfunction

	function automatic logic [BIN_W-1:0] random_freq();
		longint unsigned v;
		int r;
		int k;
		r = $urandom_range(99);
		v = 0;
		if (r < 35) begin
			v = {30'b0, 2'($urandom_range(3, 0)), 32'($urandom())};
		end else if (r < 65) begin
			for (k = 0; k < DIGITS; k++)
				v = v * 10 + $urandom_range(9, 0);
		end else if (r < 80) begin
			v = TEN_MHZ_TENTHS - 50 + $urandom_range(100, 0);
		end else if (r < 90) begin
			v = $urandom_range(999, 0);
		end else if (r < 95) begin
			v = 64'd9999999999 - $urandom_range(1000, 0);
		end else begin
			v = 64'h3_ffff_ffff - $urandom_range(1000, 0);
		end
		return v[BIN_W-1:0];
	endfunction

	// output side back-pressure
	always @(posedge clk) begin
		if (!idle_on) begin
			m_tready <= 1'b1;
		end else if (stall_left > 0) begin
			m_tready <= 1'b0;
			stall_left = stall_left - 1;
		end else begin
			m_tready <= 1'b1;
			if ($urandom_range(99) < 15)
				stall_left = pick_idle();
		end
	end

	// result checker
	always @(posedge clk) begin
		freq_code_t exp_code;
		int k;
		if (arst_n && m_tvalid && m_tready) begin
			if (code_q.size() == 0) begin
				$error("result with no request outstanding: tdata %h", m_tdata);
				errors++;
			end else begin
				exp_code = code_q.pop_front();
				for (k = 0; k < OUT_BYTES; k++)
					if (m_tdata[8*k +: 8] !== exp_code.digit_bytes[k]) begin
						$error("digit_byte%0d: expected %02h, actual %02h", k,
							exp_code.digit_bytes[k], m_tdata[8*k +: 8]);
						errors++;
					end
				if (m_tdata[8*OUT_BYTES +: SW_W] !== exp_code.switch_out) begin
					$error("switch_out: expected %04h, actual %04h",
						exp_code.switch_out, m_tdata[8*OUT_BYTES +: SW_W]);
					errors++;
				end
				if (m_tuser[0] !== exp_code.underflow) begin
					$error("underflow: expected %0b, actual %0b",
						exp_code.underflow, m_tuser[0]);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles, code_q.size());
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	task automatic send_freq(input logic [BIN_W-1:0] freq);
		int gap;
		s_tvalid <= 1'b1;
		s_tdata <= {{(IN_TDATA_W-BIN_W){1'b0}}, freq};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		code_q.push_back(encode_freq(freq, model_cfg, switch_cfg));
		n_requests++;
		gap = 0;
		if (idle_on && $urandom_range(99) >= 55)
			gap = pick_idle();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic wait_drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (code_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [SW_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		if (idx == REG_MODEL)
			model_cfg = data[MODEL_W-1:0];
		else
			switch_cfg = data;
	endtask

	task automatic set_config(input logic [SW_W-1:0] model_word, input logic [SW_W-1:0] sw);
		wait_drain();
		write_reg(REG_MODEL, model_word);
		write_reg(REG_SWITCH, sw);
		n_settings++;
	endtask

	task automatic test_reset_values();
		idle_on = 0;
		n_settings++;
		send_freq(34'd0);
		send_freq(34'd9999999999);
		send_freq(34'd1234567890);
	endtask

	task automatic test_plain_extremes();
		set_config(SW_W'(MODEL_PLAIN), 16'hffff);
		send_freq(34'd1);
		send_freq(34'd9);
		send_freq(34'd10);
		send_freq(34'd99);
		send_freq(34'd10000000000);
		send_freq(34'h3_ffff_ffff);
		send_freq(34'd9876543210);
		send_freq(34'd5555555555);
	endtask

	task automatic test_sub_10mhz();
		set_config(SW_W'(MODEL_SUB10M), 16'h0000);
		send_freq(34'd0);
		send_freq(34'd99999999);
		send_freq(34'd100000000);
		send_freq(34'd100000001);
		send_freq(34'd9999999999);
		send_freq(34'h3_ffff_ffff);
	endtask

	task automatic test_top_fixup();
		set_config(SW_W'(MODEL_TOP_FIX), 16'ha5c3);
		send_freq(34'd0);
		send_freq(34'd1000000000);
		send_freq(34'd8999999999);
		send_freq(34'd9999999999);
	endtask

	task automatic test_spare_model();
		// upper data bits of a model write are ignored, leaving the unused code
		set_config(16'hffff, 16'h8001);
		send_freq(34'd0);
		send_freq(34'd123456789);
	endtask

	task automatic test_random();
		logic [MODEL_W-1:0] models[RANDOM_PHASES];
		logic [SW_W-1:0] sw;
		int ph;
		int n;
		models = '{MODEL_PLAIN, MODEL_SUB10M, MODEL_TOP_FIX, MODEL_SPARE,
			MODEL_SUB10M, MODEL_TOP_FIX, MODEL_PLAIN, MODEL_SUB10M};
		for (ph = 0; ph < RANDOM_PHASES; ph++) begin
			case (ph % 3)
				0: sw = 16'h0000;
				1: sw = 16'hffff;
				default: sw = 16'($urandom());
			endcase
			set_config({14'($urandom()), models[ph]}, sw);
			idle_on = (ph % 4) != 0;
			for (n = 0; n < PHASE_ITEMS; n++)
				send_freq(random_freq());
		end
	endtask

	initial begin
		errors = 0;
		n_requests = 0;
		n_settings = 0;
		cycles = 0;
		stall_left = 0;
		idle_on = 0;
		model_cfg = MODEL_RESET;
		switch_cfg = SWITCH_RESET;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_values();
		test_plain_extremes();
		test_sub_10mhz();
		test_top_fixup();
		test_spare_model();
		test_random();

		wait_drain();
		idle_on = 0;
		repeat (40) @(posedge clk);
		if (code_q.size() != 0) begin
			$error("%0d expected results never arrived", code_q.size());
			errors++;
		end
		$display("sent %0d frequency requests over %0d register settings, all four model codes",
			n_requests, n_settings);
		$display("errors: %0d, cycles: %0d", errors, cycles);
		if (errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
